// ===== design/dtsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtsm_pkg
// Shared types, register codes and sine constants of the dual tone sine mixer.
// ----------------------------------------------------------------------------
package dtsm_pkg;

    localparam int PERIOD_W = 12;
    localparam int AMP_W    = 8;
    localparam int SUM_W    = 12;
    localparam int POLY_W   = 31;
    localparam int PROD_W   = 2 * POLY_W;
    localparam int XW       = 15;
    localparam int SW       = 17;
    localparam int MAG_W    = 10;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_ONE_RESET = 12'd44;
    localparam logic [PERIOD_W-1:0] PERIOD_TWO_RESET = 12'd8;
    localparam logic [AMP_W-1:0]    AMP_RESET        = 8'd150;

    localparam logic [1:0] REG_PERIOD_ONE = 2'd0;
    localparam logic [1:0] REG_PERIOD_TWO = 2'd1;
    localparam logic [1:0] REG_AMPLITUDE  = 2'd2;

    localparam logic [XW-1:0]     QUARTER_TURN = 15'd16384;
    localparam logic [SW-1:0]     SINE_ONE     = 17'd32768;
    localparam logic [POLY_W-1:0] COEF1        = 31'd1686629713;
    localparam logic [POLY_W-1:0] COEF3        = 31'd693598668;
    localparam logic [POLY_W-1:0] COEF5        = 31'd85569305;
    localparam logic [POLY_W-1:0] COEF7        = 31'd5026992;
    localparam logic [POLY_W-1:0] COEF9        = 31'd172272;

    localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 12'sd127;
    localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -12'sd128;

    typedef enum logic [4:0] {
        S_IDLE,
        S_IDX_INIT,
        S_IDX_RUN,
        S_SIN_PREP,
        S_MUL_X2,
        S_SET_X2,
        S_MUL_H,
        S_SUB_H,
        S_MUL_F,
        S_SET_S,
        S_MUL_A,
        S_ACC,
        S_MOD_INIT,
        S_MOD_RUN,
        S_MOD_DONE,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_IDX,
        OP_DIV_MOD,
        OP_DIV_STEP,
        OP_SIN_PREP,
        OP_MUL,
        OP_SET_X2,
        OP_SUB_H,
        OP_SET_S,
        OP_ACC,
        OP_PHASE,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        MUL_XX,
        MUL_H,
        MUL_F,
        MUL_A
    } mul_sel_t;

    typedef struct packed {
        op_t        op;
        mul_sel_t   mul_sel;
        logic [1:0] coef_sel;
        logic       tone;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_one;
        logic [PERIOD_W-1:0] period_two;
        logic [AMP_W-1:0]    amplitude;
    } cfg_t;

    function automatic logic [POLY_W-1:0] horner_coef(input logic [1:0] sel);
        logic [POLY_W-1:0] c;
        case (sel)
            2'd0:    c = COEF7;
            2'd1:    c = COEF5;
            2'd2:    c = COEF3;
            default: c = COEF1;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/dtsm_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtsm_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module dtsm_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dtsm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dtsm_pkg::DATA_W-1:0]   pwdata,
    output logic      [dtsm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output dtsm_pkg::cfg_t                     cfg
);

    logic [dtsm_pkg::PERIOD_W-1:0] period_one_reg;
    logic [dtsm_pkg::PERIOD_W-1:0] period_two_reg;
    logic [dtsm_pkg::AMP_W-1:0]    amplitude_reg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_one_reg <= dtsm_pkg::PERIOD_ONE_RESET;
            period_two_reg <= dtsm_pkg::PERIOD_TWO_RESET;
            amplitude_reg  <= dtsm_pkg::AMP_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                dtsm_pkg::REG_PERIOD_ONE: period_one_reg <= pwdata[dtsm_pkg::PERIOD_W-1:0];
                dtsm_pkg::REG_PERIOD_TWO: period_two_reg <= pwdata[dtsm_pkg::PERIOD_W-1:0];
                dtsm_pkg::REG_AMPLITUDE:  amplitude_reg  <= pwdata[dtsm_pkg::AMP_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            dtsm_pkg::REG_PERIOD_ONE: prdata = dtsm_pkg::DATA_W'(period_one_reg);
            dtsm_pkg::REG_PERIOD_TWO: prdata = dtsm_pkg::DATA_W'(period_two_reg);
            dtsm_pkg::REG_AMPLITUDE:  prdata = dtsm_pkg::DATA_W'(amplitude_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.period_one = period_one_reg;
    assign cfg.period_two = period_two_reg;
    assign cfg.amplitude  = amplitude_reg;

endmodule
`default_nettype wire

// ===== design/dtsm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtsm_ctrl
// Sequencer that steps the datapath through both tones of one item.
// ----------------------------------------------------------------------------
module dtsm_ctrl #(
    parameter int DIV_BITS = 22
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire dtsm_pkg::status_t status,
    output dtsm_pkg::cmd_t         cmd
);

    localparam int CNT_W = $clog2(DIV_BITS);

    dtsm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       hcnt_reg, hcnt_next;
    logic             tone_reg, tone_next;
    logic             cnt_last;

    assign cnt_last   = (cnt_reg == CNT_W'(DIV_BITS - 1));
    assign item_stall = (state_reg != dtsm_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtsm_pkg::S_IDLE;
            cnt_reg   <= '0;
            hcnt_reg  <= '0;
            tone_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hcnt_reg  <= hcnt_next;
            tone_reg  <= tone_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtsm_pkg::S_IDLE:     if (item_valid) state_next = dtsm_pkg::S_IDX_INIT;
            dtsm_pkg::S_IDX_INIT: state_next = dtsm_pkg::S_IDX_RUN;
            dtsm_pkg::S_IDX_RUN:  if (cnt_last) state_next = dtsm_pkg::S_SIN_PREP;
            dtsm_pkg::S_SIN_PREP: state_next = dtsm_pkg::S_MUL_X2;
            dtsm_pkg::S_MUL_X2:   state_next = dtsm_pkg::S_SET_X2;
            dtsm_pkg::S_SET_X2:   state_next = dtsm_pkg::S_MUL_H;
            dtsm_pkg::S_MUL_H:    state_next = dtsm_pkg::S_SUB_H;
            dtsm_pkg::S_SUB_H:
                state_next = (hcnt_reg == 2'd3) ? dtsm_pkg::S_MUL_F : dtsm_pkg::S_MUL_H;
            dtsm_pkg::S_MUL_F:    state_next = dtsm_pkg::S_SET_S;
            dtsm_pkg::S_SET_S:    state_next = dtsm_pkg::S_MUL_A;
            dtsm_pkg::S_MUL_A:    state_next = dtsm_pkg::S_ACC;
            dtsm_pkg::S_ACC:      state_next = dtsm_pkg::S_MOD_INIT;
            dtsm_pkg::S_MOD_INIT: state_next = dtsm_pkg::S_MOD_RUN;
            dtsm_pkg::S_MOD_RUN:  if (cnt_last) state_next = dtsm_pkg::S_MOD_DONE;
            dtsm_pkg::S_MOD_DONE:
                state_next = tone_reg ? dtsm_pkg::S_OUT : dtsm_pkg::S_IDX_INIT;
            dtsm_pkg::S_OUT:      if (status.out_free) state_next = dtsm_pkg::S_IDLE;
            default:              state_next = dtsm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        hcnt_next = hcnt_reg;
        tone_next = tone_reg;
        case (state_reg)
            dtsm_pkg::S_IDLE:     tone_next = 1'b0;
            dtsm_pkg::S_IDX_INIT: cnt_next  = '0;
            dtsm_pkg::S_IDX_RUN:  cnt_next  = cnt_reg + 1'b1;
            dtsm_pkg::S_SET_X2:   hcnt_next = '0;
            dtsm_pkg::S_SUB_H:    hcnt_next = hcnt_reg + 1'b1;
            dtsm_pkg::S_MOD_INIT: cnt_next  = '0;
            dtsm_pkg::S_MOD_RUN:  cnt_next  = cnt_reg + 1'b1;
            dtsm_pkg::S_MOD_DONE: tone_next = 1'b1;
            default:              ;
        endcase
    end

    always_comb
    begin
        cmd.op       = dtsm_pkg::OP_NONE;
        cmd.mul_sel  = dtsm_pkg::MUL_XX;
        cmd.coef_sel = hcnt_reg;
        cmd.tone     = tone_reg;
        case (state_reg)
            dtsm_pkg::S_IDLE:     if (item_valid) cmd.op = dtsm_pkg::OP_LOAD;
            dtsm_pkg::S_IDX_INIT: cmd.op = dtsm_pkg::OP_DIV_IDX;
            dtsm_pkg::S_IDX_RUN:  cmd.op = dtsm_pkg::OP_DIV_STEP;
            dtsm_pkg::S_SIN_PREP: cmd.op = dtsm_pkg::OP_SIN_PREP;
            dtsm_pkg::S_MUL_X2:
            begin
                cmd.op      = dtsm_pkg::OP_MUL;
                cmd.mul_sel = dtsm_pkg::MUL_XX;
            end
            dtsm_pkg::S_SET_X2:   cmd.op = dtsm_pkg::OP_SET_X2;
            dtsm_pkg::S_MUL_H:
            begin
                cmd.op      = dtsm_pkg::OP_MUL;
                cmd.mul_sel = dtsm_pkg::MUL_H;
            end
            dtsm_pkg::S_SUB_H:    cmd.op = dtsm_pkg::OP_SUB_H;
            dtsm_pkg::S_MUL_F:
            begin
                cmd.op      = dtsm_pkg::OP_MUL;
                cmd.mul_sel = dtsm_pkg::MUL_F;
            end
            dtsm_pkg::S_SET_S:    cmd.op = dtsm_pkg::OP_SET_S;
            dtsm_pkg::S_MUL_A:
            begin
                cmd.op      = dtsm_pkg::OP_MUL;
                cmd.mul_sel = dtsm_pkg::MUL_A;
            end
            dtsm_pkg::S_ACC:      cmd.op = dtsm_pkg::OP_ACC;
            dtsm_pkg::S_MOD_INIT: cmd.op = dtsm_pkg::OP_DIV_MOD;
            dtsm_pkg::S_MOD_RUN:  cmd.op = dtsm_pkg::OP_DIV_STEP;
            dtsm_pkg::S_MOD_DONE: cmd.op = dtsm_pkg::OP_PHASE;
            dtsm_pkg::S_OUT:      if (status.out_free) cmd.op = dtsm_pkg::OP_OUT;
            default:              cmd.op = dtsm_pkg::OP_NONE;
        endcase
    end

    a_out_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == dtsm_pkg::OP_OUT) |-> status.out_free)
        else $error("result loaded while the output register is still full");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("a second item was taken before the first one finished");

    a_div_count_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtsm_pkg::S_IDX_INIT || state_reg == dtsm_pkg::S_MOD_INIT)
        |=> (cnt_reg == '0))
        else $error("divider step count did not restart");

    a_second_tone_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtsm_pkg::S_MOD_DONE && tone_reg) |=> (state_reg == dtsm_pkg::S_OUT))
        else $error("sequencer did not finish after the second tone");

endmodule
`default_nettype wire

// ===== design/dtsm_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtsm_dp
// Datapath: phase counters, serial divider, shared multiplier, mixer and
// output register.
// ----------------------------------------------------------------------------
module dtsm_dp #(
    parameter int PHASE_BITS = 12,
    parameter int ANGLE_BITS = 10
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dtsm_pkg::cmd_t cmd,
    output dtsm_pkg::status_t   status,
    input  wire dtsm_pkg::cfg_t cfg,
    input  wire logic           slot_last,
    output logic                result_valid,
    input  wire logic           result_stall,
    output logic signed [7:0]   sample,
    output logic                clipped,
    output logic                last
);

    localparam int DIV_BITS = PHASE_BITS + ANGLE_BITS;
    localparam int PW       = dtsm_pkg::PERIOD_W;
    localparam int POLY_W   = dtsm_pkg::POLY_W;
    localparam int PROD_W   = dtsm_pkg::PROD_W;
    localparam int XW       = dtsm_pkg::XW;
    localparam int SW       = dtsm_pkg::SW;
    localparam int SUM_W    = dtsm_pkg::SUM_W;
    localparam int MAG_W    = dtsm_pkg::MAG_W;

    logic [PHASE_BITS-1:0]  phase_one_reg, phase_two_reg;
    logic                   last_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [PW-1:0]          rem_reg;
    logic [DIV_BITS-1:0]    quo_reg;
    logic [XW-1:0]          x_reg;
    logic                   neg_reg;
    logic                   special_reg;
    logic [POLY_W-1:0]      x2_reg;
    logic [POLY_W-1:0]      p_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SW-1:0]          s_reg;
    logic                   out_valid_reg, out_valid_next;
    logic signed [7:0]      sample_reg;
    logic                   clipped_reg;
    logic                   last_out_reg;

    logic [PW-1:0]          period_sel;
    logic [PHASE_BITS-1:0]  phase_sel;
    logic [PW:0]            rem_shift;
    logic [PW:0]            rem_diff;
    logic                   rem_ge;
    logic [ANGLE_BITS-1:0]  angle;
    logic [15:0]            turn;
    logic [XW-1:0]          x_raw;
    logic [XW-1:0]          x_fold;
    logic [POLY_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]      prod_next;
    logic [46:0]            rounded;
    logic [MAG_W-1:0]       mag;
    logic signed [SUM_W-1:0] tone_val;
    logic signed [SUM_W-1:0] sum_clip;
    logic                   clip_flag;
    logic                   period_zero;

    assign period_sel  = cmd.tone ? cfg.period_two : cfg.period_one;
    assign phase_sel   = cmd.tone ? phase_two_reg : phase_one_reg;
    assign period_zero = (period_sel == '0);

    assign rem_shift = {rem_reg, quo_reg[DIV_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, period_sel};
    assign rem_ge    = (rem_shift >= {1'b0, period_sel});

    assign angle  = quo_reg[ANGLE_BITS-1:0];
    assign turn   = {angle, {(16 - ANGLE_BITS){1'b0}}};
    assign x_raw  = {1'b0, turn[13:0]};
    assign x_fold = turn[14] ? (dtsm_pkg::QUARTER_TURN - x_raw) : x_raw;

    always_comb
    begin
        case (cmd.mul_sel)
            dtsm_pkg::MUL_XX:
            begin
                mul_a = POLY_W'(x_reg);
                mul_b = POLY_W'(x_reg);
            end
            dtsm_pkg::MUL_H:
            begin
                mul_a = x2_reg;
                mul_b = p_reg;
            end
            dtsm_pkg::MUL_F:
            begin
                mul_a = POLY_W'(x_reg);
                mul_b = p_reg;
            end
            default:
            begin
                mul_a = POLY_W'(cfg.amplitude);
                mul_b = POLY_W'(s_reg);
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign rounded   = {1'b0, prod_reg[45:0]} + (47'd1 << 28);
    assign mag       = prod_reg[15 +: MAG_W];

    always_comb
    begin
        if (period_zero)
            tone_val = '0;
        else if (neg_reg)
            tone_val = -$signed({{(SUM_W - MAG_W){1'b0}}, mag});
        else
            tone_val = $signed({{(SUM_W - MAG_W){1'b0}}, mag});
    end

    always_comb
    begin
        clip_flag = 1'b0;
        sum_clip  = sum_reg;
        if (sum_reg > dtsm_pkg::SAMPLE_MAX)
        begin
            sum_clip  = dtsm_pkg::SAMPLE_MAX;
            clip_flag = 1'b1;
        end
        else if (sum_reg < dtsm_pkg::SAMPLE_MIN)
        begin
            sum_clip  = dtsm_pkg::SAMPLE_MIN;
            clip_flag = 1'b1;
        end
    end

    assign status.out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == dtsm_pkg::OP_OUT)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_one_reg <= '0;
            phase_two_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.op == dtsm_pkg::OP_PHASE)
            begin
                if (cmd.tone)
                    phase_two_reg <= period_zero ? '0 : PHASE_BITS'(rem_reg);
                else
                    phase_one_reg <= period_zero ? '0 : PHASE_BITS'(rem_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            dtsm_pkg::OP_LOAD:
            begin
                last_reg <= slot_last;
                sum_reg  <= '0;
            end
            dtsm_pkg::OP_DIV_IDX:
            begin
                rem_reg <= '0;
                quo_reg <= {phase_sel, {ANGLE_BITS{1'b0}}};
            end
            dtsm_pkg::OP_DIV_MOD:
            begin
                rem_reg <= '0;
                quo_reg <= DIV_BITS'({1'b0, phase_sel} + (PHASE_BITS + 1)'(1));
            end
            dtsm_pkg::OP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? rem_diff[PW-1:0] : rem_shift[PW-1:0];
                quo_reg <= {quo_reg[DIV_BITS-2:0], rem_ge};
            end
            dtsm_pkg::OP_SIN_PREP:
            begin
                x_reg       <= x_fold;
                neg_reg     <= turn[15];
                special_reg <= (x_fold == dtsm_pkg::QUARTER_TURN);
            end
            dtsm_pkg::OP_MUL:
                prod_reg <= prod_next;
            dtsm_pkg::OP_SET_X2:
            begin
                x2_reg <= {prod_reg[POLY_W-3:0], 2'b00};
                p_reg  <= dtsm_pkg::COEF9;
            end
            dtsm_pkg::OP_SUB_H:
                p_reg <= dtsm_pkg::horner_coef(cmd.coef_sel) - prod_reg[30 +: POLY_W];
            dtsm_pkg::OP_SET_S:
                s_reg <= special_reg ? dtsm_pkg::SINE_ONE : rounded[29 +: SW];
            dtsm_pkg::OP_ACC:
                sum_reg <= sum_reg + tone_val;
            dtsm_pkg::OP_OUT:
            begin
                sample_reg   <= sum_clip[7:0];
                clipped_reg  <= clip_flag;
                last_out_reg <= last_reg;
            end
            default: ;
        endcase
    end

    assign result_valid = out_valid_reg;
    assign sample       = sample_reg;
    assign clipped      = clipped_reg;
    assign last         = last_out_reg;

    a_clip_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == dtsm_pkg::OP_OUT) |=>
            (clipped_reg == (($past(sum_reg) > dtsm_pkg::SAMPLE_MAX) ||
                             ($past(sum_reg) < dtsm_pkg::SAMPLE_MIN))))
        else $error("clip flag disagrees with the mixed sum");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == dtsm_pkg::OP_OUT) |=> out_valid_reg)
        else $error("loaded result is not presented");

endmodule
`default_nettype wire

// ===== design/dual_tone_sine_mixer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_tone_sine_mixer
// Two table-free sine tones with configurable periods, summed and clipped to
// a signed 8-bit sample per item.
//
//   Channel   Signals                                  Direction
//   item      item_valid, item_stall, slot_last        in
//   result    result_valid, result_stall, sample,
//             clipped, last                            out
//   config    psel, penable, pwrite, paddr, pwdata,
//             prdata, pready                           in/out
//
// An item is accepted only while the sequencer is idle, so a new item waits
// until the one before it is through; the bit-serial divider is run once for
// the angle and once for the phase wrap of each tone.
// Reset puts the periods at 44 and 8, the amplitude at 150, both phases at 0.
// A result waits in the output register while the next item is computed; the
// sequencer holds only if that register is still full when the next result
// is ready.
// ----------------------------------------------------------------------------
module dual_tone_sine_mixer #(
    parameter int PHASE_BITS = 12,
    parameter int ANGLE_BITS = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dtsm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dtsm_pkg::DATA_W-1:0] pwdata,
    output logic      [dtsm_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic                        slot_last,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic signed [7:0]                sample,
    output logic                             clipped,
    output logic                             last
);

    dtsm_pkg::cfg_t    cfg;
    dtsm_pkg::cmd_t    cmd;
    dtsm_pkg::status_t status;

    dtsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dtsm_ctrl #(
        .DIV_BITS (PHASE_BITS + ANGLE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    dtsm_dp #(
        .PHASE_BITS (PHASE_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .slot_last    (slot_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample       (sample),
        .clipped      (clipped),
        .last         (last)
    );

endmodule
`default_nettype wire
